[hw/rtl/continuation_history_update_unit_assert.svh]
// Assertion macros shared by the checker of the continuation history update unit.
// Depends on nothing; included by chu_checker.sv.
`ifndef CONTINUATION_HISTORY_UPDATE_UNIT_ASSERT_SVH
`define CONTINUATION_HISTORY_UPDATE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("chu_checker: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("chu_checker: next-cycle check failed");

`endif

[hw/rtl/chu_pkg.sv]
// Package of the continuation history update unit: codes, widths and helpers.
// Used by continuation_history_update_unit; depends on nothing.
package chu_pkg;

  // Default table geometry.
  localparam int unsigned PIECE_KINDS_DEF = 12;
  localparam int unsigned SQUARES_DEF     = 64;

  // Field widths.
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned SUM_W   = 33;
  localparam int unsigned DELTA_W = 46;
  localparam int unsigned LIMIT_W = 21;
  localparam int unsigned BONUS_W = 11;
  localparam int unsigned PROD_W  = 45;

  // Divider: quotient magnitude width and two quotient bits per cycle.
  localparam int unsigned DIV_W    = 44;
  localparam int unsigned DIV_ITER = DIV_W / 2;
  localparam int unsigned DIV_CW   = $clog2(DIV_ITER);

  localparam int unsigned        BONUS_CAP    = 1200;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(16384);

  // Operation codes; code 3 behaves as a query.
  localparam logic [1:0] OP_QUERY    = 2'd0;
  localparam logic [1:0] OP_REWARD   = 2'd1;
  localparam logic [1:0] OP_PENALIZE = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_CAP,
    ST_SUM,
    ST_MUL,
    ST_ABS,
    ST_DIV,
    ST_SGN,
    ST_DLT,
    ST_WRD1,
    ST_WR1,
    ST_WRD2,
    ST_WR2,
    ST_DONE
  } chu_state_e;

  typedef struct packed {
    logic [LIMIT_W-1:0] rem;
    logic               qbit;
  } div_step_t;

  // One restoring division step: shift in a dividend bit, subtract if it fits.
  function automatic div_step_t div_step(logic [LIMIT_W-1:0] rem, logic din,
                                         logic [LIMIT_W-1:0] lim);
    logic [LIMIT_W:0] r;
    logic [LIMIT_W:0] diff;
    div_step_t        res;
    r    = {rem, din};
    diff = r - {1'b0, lim};
    if (r >= {1'b0, lim}) begin
      res.rem  = diff[LIMIT_W-1:0];
      res.qbit = 1'b1;
    end else begin
      res.rem  = r[LIMIT_W-1:0];
      res.qbit = 1'b0;
    end
    return res;
  endfunction

  // Adds a delta to an entry and clamps to the symmetric 32-bit range.
  function automatic logic [SCORE_W-1:0] sat_add(logic signed [SCORE_W-1:0] e,
                                                 logic signed [DELTA_W-1:0] d);
    logic signed [DELTA_W:0] s;
    logic signed [DELTA_W:0] smax;
    smax = (DELTA_W+1)'(64'sd2147483647);
    s    = (DELTA_W+1)'(e) + (DELTA_W+1)'(d);
    if (s > smax) begin
      s = smax;
    end else if (s < -smax) begin
      s = -smax;
    end
    return s[SCORE_W-1:0];
  endfunction

endpackage

[hw/rtl/continuation_history_update_unit.sv]
// Continuation history update unit: score table in one synchronous RAM with
// read-modify-write sequencing and an iterative gravity divider.
// Depends on chu_pkg.
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+-----------------------------------
//  command   | in        | start_i, busy_o        | operation_i .. ply_i
//  result    | out       | done_o (one-cycle beat)| first/second/sum_score_o, delta
//  config    | in        | cfg_we_i               | cfg_wdata_i (gravity limit)
//
// A query does two reads on the single RAM port, a capture and a sum; a reward or
// penalty then multiplies, takes the magnitude, runs the two-bit-per-cycle divider,
// restores the sign, forms the delta and does a read and write per entry written.
// After reset a clearing pass writes zero to every entry, one per cycle, over all
// PIECE_KINDS*SQUARES*PIECE_KINDS*SQUARES entries (589824 at the defaults), busy high.
// The result beat cannot be stalled; busy_o stays high until it has been shown.
module continuation_history_update_unit #(
  parameter int unsigned PIECE_KINDS = chu_pkg::PIECE_KINDS_DEF,
  parameter int unsigned SQUARES     = chu_pkg::SQUARES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [chu_pkg::LIMIT_W-1:0]         cfg_wdata_i,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          operation_i,
  input  logic [7:0]                          depth_i,
  input  logic [3:0]                          cur_piece_i,
  input  logic [5:0]                          to_square_i,
  input  logic [3:0]                          prev1_piece_i,
  input  logic [5:0]                          prev1_to_i,
  input  logic                                prev1_present_i,
  input  logic [3:0]                          prev2_piece_i,
  input  logic [5:0]                          prev2_to_i,
  input  logic                                prev2_present_i,
  input  logic [7:0]                          ply_i,
  output logic                                done_o,
  output logic signed [chu_pkg::SCORE_W-1:0]  first_score_o,
  output logic signed [chu_pkg::SCORE_W-1:0]  second_score_o,
  output logic signed [chu_pkg::SUM_W-1:0]    sum_score_o,
  output logic signed [chu_pkg::DELTA_W-1:0]  applied_delta_o
);

  localparam int unsigned TBL_DEPTH = PIECE_KINDS * SQUARES * PIECE_KINDS * SQUARES;
  localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);

  chu_pkg::chu_state_e state_q, state_d;

  // Control registers.
  logic [TBL_AW-1:0]             clr_q;
  logic [chu_pkg::DIV_CW-1:0]    cnt_q;
  logic [chu_pkg::LIMIT_W-1:0]   limit_q;

  // Latched command and datapath registers.
  logic [1:0]                          op_q;
  logic [7:0]                          depth_q;
  logic [7:0]                          ply_q;
  logic                                pr1_q, pr2_q, ok1_q, ok2_q;
  logic [TBL_AW-1:0]                   slot1_q, slot2_q;
  logic [chu_pkg::BONUS_W-1:0]         bonus_q;
  logic signed [chu_pkg::SCORE_W-1:0]  e1_q, e2_q;
  logic signed [chu_pkg::SUM_W-1:0]    sum_q;
  logic signed [chu_pkg::PROD_W-1:0]   prod_q;
  logic                                neg_q;
  logic [chu_pkg::DIV_W-1:0]           quo_q;
  logic [chu_pkg::LIMIT_W-1:0]         rem_q;
  logic signed [chu_pkg::DELTA_W-1:0]  qs_q, delta_q;

  // Table memory.
  logic [chu_pkg::SCORE_W-1:0] table_mem [TBL_DEPTH];
  logic [chu_pkg::SCORE_W-1:0] rd_data_q;
  logic                        mem_we;
  logic [TBL_AW-1:0]           mem_addr;
  logic [chu_pkg::SCORE_W-1:0] mem_wdata;

  // Combinational helpers.
  logic [31:0]                       slot1_full, slot2_full;
  logic                              ok1, ok2;
  logic                              accept;
  logic                              is_update, is_penalty;
  logic                              gate1, gate2;
  logic [chu_pkg::LIMIT_W-1:0]       lim;
  logic [15:0]                       depth_sq;
  logic signed [chu_pkg::PROD_W-1:0] prod_neg;
  chu_pkg::div_step_t                step_a, step_b;

  assign accept     = start_i && !busy_o;
  assign is_update  = (op_q == chu_pkg::OP_REWARD) || (op_q == chu_pkg::OP_PENALIZE);
  assign is_penalty = (op_q == chu_pkg::OP_PENALIZE);
  assign gate1      = ok1_q && (ply_q != 8'd0);
  assign gate2      = ok2_q && (ply_q > 8'd1);
  assign lim        = (limit_q == '0) ? chu_pkg::LIMIT_W'(1) : limit_q;
  assign depth_sq   = 16'(depth_q) * 16'(depth_q);
  assign prod_neg   = -prod_q;

  // Table slots of both earlier moves and their range checks.
  always_comb begin
    slot1_full = 32'((((32'(prev1_piece_i) * SQUARES + 32'(prev1_to_i)) * PIECE_KINDS
                 + 32'(cur_piece_i)) * SQUARES) + 32'(to_square_i));
    slot2_full = 32'((((32'(prev2_piece_i) * SQUARES + 32'(prev2_to_i)) * PIECE_KINDS
                 + 32'(cur_piece_i)) * SQUARES) + 32'(to_square_i));
    ok1 = (32'(prev1_piece_i) < PIECE_KINDS) && (32'(cur_piece_i) < PIECE_KINDS)
       && (32'(prev1_to_i) < SQUARES) && (32'(to_square_i) < SQUARES);
    ok2 = (32'(prev2_piece_i) < PIECE_KINDS) && (32'(cur_piece_i) < PIECE_KINDS)
       && (32'(prev2_to_i) < SQUARES) && (32'(to_square_i) < SQUARES);
  end

  // Two division steps per cycle.
  always_comb begin
    step_a = chu_pkg::div_step(rem_q, quo_q[chu_pkg::DIV_W-1], lim);
    step_b = chu_pkg::div_step(step_a.rem, quo_q[chu_pkg::DIV_W-2], lim);
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      chu_pkg::ST_CLEAR: begin
        if (clr_q == TBL_AW'(TBL_DEPTH - 1)) state_d = chu_pkg::ST_IDLE;
      end
      chu_pkg::ST_IDLE: begin
        if (accept) state_d = chu_pkg::ST_RD1;
      end
      chu_pkg::ST_RD1: state_d = chu_pkg::ST_RD2;
      chu_pkg::ST_RD2: state_d = chu_pkg::ST_CAP;
      chu_pkg::ST_CAP: state_d = chu_pkg::ST_SUM;
      chu_pkg::ST_SUM: state_d = is_update ? chu_pkg::ST_MUL : chu_pkg::ST_DONE;
      chu_pkg::ST_MUL: state_d = chu_pkg::ST_ABS;
      chu_pkg::ST_ABS: state_d = chu_pkg::ST_DIV;
      chu_pkg::ST_DIV: begin
        if (cnt_q == chu_pkg::DIV_CW'(chu_pkg::DIV_ITER - 1)) state_d = chu_pkg::ST_SGN;
      end
      chu_pkg::ST_SGN: state_d = chu_pkg::ST_DLT;
      chu_pkg::ST_DLT: begin
        if (gate1) begin
          state_d = chu_pkg::ST_WRD1;
        end else if (gate2) begin
          state_d = chu_pkg::ST_WRD2;
        end else begin
          state_d = chu_pkg::ST_DONE;
        end
      end
      chu_pkg::ST_WRD1: state_d = chu_pkg::ST_WR1;
      chu_pkg::ST_WR1:  state_d = gate2 ? chu_pkg::ST_WRD2 : chu_pkg::ST_DONE;
      chu_pkg::ST_WRD2: state_d = chu_pkg::ST_WR2;
      chu_pkg::ST_WR2:  state_d = chu_pkg::ST_DONE;
      chu_pkg::ST_DONE: state_d = chu_pkg::ST_IDLE;
      default:          state_d = chu_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory port control, busy and result strobe.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = slot1_q;
    mem_wdata = '0;
    busy_o    = 1'b1;
    done_o    = 1'b0;
    case (state_q)
      chu_pkg::ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
      end
      chu_pkg::ST_IDLE: busy_o = 1'b0;
      chu_pkg::ST_RD1:  mem_addr = slot1_q;
      chu_pkg::ST_RD2:  mem_addr = slot2_q;
      chu_pkg::ST_WRD1: mem_addr = slot1_q;
      chu_pkg::ST_WR1: begin
        mem_we    = 1'b1;
        mem_addr  = slot1_q;
        mem_wdata = chu_pkg::sat_add($signed(rd_data_q), delta_q);
      end
      chu_pkg::ST_WRD2: mem_addr = slot2_q;
      chu_pkg::ST_WR2: begin
        mem_we    = 1'b1;
        mem_addr  = slot2_q;
        mem_wdata = chu_pkg::sat_add($signed(rd_data_q), delta_q);
      end
      chu_pkg::ST_DONE: done_o = 1'b1;
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Table RAM with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_addr] <= mem_wdata;
    end
    rd_data_q <= table_mem[mem_addr];
  end

  // Control state: sequencer, clear sweep, divider count and the limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chu_pkg::ST_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      limit_q <= chu_pkg::LIMIT_RESET;
    end else begin
      state_q <= state_d;
      if (state_q == chu_pkg::ST_CLEAR) begin
        clr_q <= clr_q + TBL_AW'(1);
      end
      if (state_q == chu_pkg::ST_DIV) begin
        cnt_q <= cnt_q + chu_pkg::DIV_CW'(1);
      end else begin
        cnt_q <= '0;
      end
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      chu_pkg::ST_IDLE: begin
        if (accept) begin
          op_q    <= operation_i;
          depth_q <= depth_i;
          ply_q   <= ply_i;
          pr1_q   <= prev1_present_i;
          pr2_q   <= prev2_present_i;
          ok1_q   <= ok1;
          ok2_q   <= ok2;
          slot1_q <= slot1_full[TBL_AW-1:0];
          slot2_q <= slot2_full[TBL_AW-1:0];
        end
      end
      chu_pkg::ST_RD1: begin
        bonus_q <= (depth_sq > 16'(chu_pkg::BONUS_CAP))
                 ? chu_pkg::BONUS_W'(chu_pkg::BONUS_CAP) : depth_sq[chu_pkg::BONUS_W-1:0];
      end
      chu_pkg::ST_RD2: begin
        e1_q <= (pr1_q && ok1_q) ? $signed(rd_data_q) : '0;
      end
      chu_pkg::ST_CAP: begin
        e2_q <= (pr2_q && ok2_q) ? $signed(rd_data_q) : '0;
      end
      chu_pkg::ST_SUM: begin
        sum_q   <= chu_pkg::SUM_W'(e1_q) + chu_pkg::SUM_W'(e2_q);
        delta_q <= '0;
      end
      chu_pkg::ST_MUL: begin
        prod_q <= sum_q * $signed({1'b0, bonus_q});
      end
      chu_pkg::ST_ABS: begin
        neg_q <= prod_q[chu_pkg::PROD_W-1];
        quo_q <= prod_q[chu_pkg::PROD_W-1] ? prod_neg[chu_pkg::DIV_W-1:0]
                                           : prod_q[chu_pkg::DIV_W-1:0];
        rem_q <= '0;
      end
      chu_pkg::ST_DIV: begin
        rem_q <= step_b.rem;
        quo_q <= {quo_q[chu_pkg::DIV_W-3:0], step_a.qbit, step_b.qbit};
      end
      chu_pkg::ST_SGN: begin
        qs_q <= neg_q ? -$signed(chu_pkg::DELTA_W'(quo_q))
                      : $signed(chu_pkg::DELTA_W'(quo_q));
      end
      chu_pkg::ST_DLT: begin
        delta_q <= is_penalty ? (qs_q - $signed(chu_pkg::DELTA_W'(bonus_q)))
                              : ($signed(chu_pkg::DELTA_W'(bonus_q)) - qs_q);
      end
      default: begin
        neg_q <= neg_q;
      end
    endcase
  end

  assign first_score_o   = e1_q;
  assign second_score_o  = e2_q;
  assign sum_score_o     = sum_q;
  assign applied_delta_o = delta_q;

endmodule

[hw/rtl/chu_checker.sv]
// Port-level checker for the continuation history update unit, bound to the top level.
// Depends on continuation_history_update_unit_assert.svh and chu_pkg.
`include "continuation_history_update_unit_assert.svh"

module chu_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start_i,
  input logic                               busy_o,
  input logic                               done_o,
  input logic signed [chu_pkg::SCORE_W-1:0] first_score_o,
  input logic signed [chu_pkg::SCORE_W-1:0] second_score_o,
  input logic signed [chu_pkg::SUM_W-1:0]   sum_score_o
);

  // A result beat only appears while the unit still reports busy.
  `CHU_ASSERT_NOW(a_done_while_busy, clk_i, rst_ni, done_o, busy_o)

  // An accepted command beat makes the unit busy on the next cycle.
  `CHU_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)

  // The result strobe lasts exactly one cycle.
  `CHU_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)

  // The reported sum matches the two reported entries.
  `CHU_ASSERT_NOW(a_sum_match, clk_i, rst_ni, done_o,
    sum_score_o == (chu_pkg::SUM_W'(first_score_o) + chu_pkg::SUM_W'(second_score_o)))

endmodule

bind continuation_history_update_unit chu_checker u_chu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .first_score_o  (first_score_o),
  .second_score_o (second_score_o),
  .sum_score_o    (sum_score_o)
);

[bench/tb_top.sv]
// Self-checking bench for the continuation history update unit: directed corner moves,
// then random search-node traffic under several gravity limits, checked beat by beat.
// Depends on chu_pkg and continuation_history_update_unit.
`timescale 1ns / 1ps

module tb_top;

  // Table geometry and limits mirrored by the score table below.
  localparam int     PIECES         = chu_pkg::PIECE_KINDS_DEF;
  localparam int     SQUARES        = chu_pkg::SQUARES_DEF;
  localparam int     TABLE_ENTRIES  = PIECES * SQUARES * PIECES * SQUARES;
  localparam longint SCORE_CLAMP    = 64'sd2147483647;
  localparam longint BONUS_MAX      = chu_pkg::BONUS_CAP;
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int     WATCHDOG_LIMIT = 1800000;
  localparam int     SETTLE_CYCLES  = 80;
  localparam int     GAP_PCT        = 35;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] depth;
    logic [3:0] cur_piece;
    logic [5:0] to_square;
    logic [3:0] prev1_piece;
    logic [5:0] prev1_to;
    logic       prev1_present;
    logic [3:0] prev2_piece;
    logic [5:0] prev2_to;
    logic       prev2_present;
    logic [7:0] ply;
  } move_cmd_t;

  typedef struct packed {
    logic [chu_pkg::SCORE_W-1:0] first_score;
    logic [chu_pkg::SCORE_W-1:0] second_score;
    logic [chu_pkg::SUM_W-1:0]   sum_score;
    logic [chu_pkg::DELTA_W-1:0] applied_delta;
  } score_beat_t;

  logic                        clk_i           = 1'b0;
  logic                        rst_ni          = 1'b0;
  logic                        cfg_we_i        = 1'b0;
  logic [chu_pkg::LIMIT_W-1:0] cfg_wdata_i     = '0;
  logic                        start_i         = 1'b0;
  logic [1:0]                  operation_i     = chu_pkg::OP_QUERY;
  logic [7:0]                  depth_i         = '0;
  logic [3:0]                  cur_piece_i     = '0;
  logic [5:0]                  to_square_i     = '0;
  logic [3:0]                  prev1_piece_i   = '0;
  logic [5:0]                  prev1_to_i      = '0;
  logic                        prev1_present_i = 1'b0;
  logic [3:0]                  prev2_piece_i   = '0;
  logic [5:0]                  prev2_to_i      = '0;
  logic                        prev2_present_i = 1'b0;
  logic [7:0]                  ply_i           = '0;

  logic                                busy_o;
  logic                                done_o;
  logic signed [chu_pkg::SCORE_W-1:0]  first_score_o;
  logic signed [chu_pkg::SCORE_W-1:0]  second_score_o;
  logic signed [chu_pkg::SUM_W-1:0]    sum_score_o;
  logic signed [chu_pkg::DELTA_W-1:0]  applied_delta_o;

  // Mirror of the score table and the gravity limit, plus the beats still owed.
  int                          score_mirror [TABLE_ENTRIES];
  logic [chu_pkg::LIMIT_W-1:0] gravity_limit_model = chu_pkg::LIMIT_RESET;
  score_beat_t                 pending_scores [$];

  int mismatches      = 0;
  int items_sent      = 0;
  int updates_sent    = 0;
  int results_checked = 0;
  int limits_written  = 0;
  int quiet_cycles    = 0;

  always #2 clk_i = ~clk_i;

  continuation_history_update_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .operation_i     (operation_i),
    .depth_i         (depth_i),
    .cur_piece_i     (cur_piece_i),
    .to_square_i     (to_square_i),
    .prev1_piece_i   (prev1_piece_i),
    .prev1_to_i      (prev1_to_i),
    .prev1_present_i (prev1_present_i),
    .prev2_piece_i   (prev2_piece_i),
    .prev2_to_i      (prev2_to_i),
    .prev2_present_i (prev2_present_i),
    .ply_i           (ply_i),
    .done_o          (done_o),
    .first_score_o   (first_score_o),
    .second_score_o  (second_score_o),
    .sum_score_o     (sum_score_o),
    .applied_delta_o (applied_delta_o)
  );

  // Table slot of a (earlier move, current move) pair, or -1 when off the board.
  function automatic int slot_of_move(input logic [3:0] pp, input logic [5:0] pt,
                                      input logic [3:0] cp, input logic [5:0] ct);
    if (pp >= PIECES || cp >= PIECES || pt >= SQUARES || ct >= SQUARES) begin
      return -1;
    end
    return (((int'(pp) * SQUARES + int'(pt)) * PIECES + int'(cp)) * SQUARES) + int'(ct);
  endfunction

  function automatic longint read_score(input int slot);
    if (slot < 0) begin
      return 0;
    end
    return score_mirror[slot];
  endfunction

  // Adds a delta to one entry and clamps it to the symmetric 32-bit range.
  function automatic void bump_score(input int slot, input longint delta);
    longint v;
    if (slot < 0) begin
      return;
    end
    v = read_score(slot) + delta;
    if (v > SCORE_CLAMP) begin
      v = SCORE_CLAMP;
    end else if (v < -SCORE_CLAMP) begin
      v = -SCORE_CLAMP;
    end
    score_mirror[slot] = int'(v);
  endfunction

  // Works out the result beat of one move and applies its update to the mirror.
  function automatic score_beat_t apply_move(input move_cmd_t m);
    int          s1;
    int          s2;
    longint      e1;
    longint      e2;
    longint      total;
    longint      bonus;
    longint      lim;
    longint      delta;
    score_beat_t r;
    s1    = slot_of_move(m.prev1_piece, m.prev1_to, m.cur_piece, m.to_square);
    s2    = slot_of_move(m.prev2_piece, m.prev2_to, m.cur_piece, m.to_square);
    e1    = m.prev1_present ? read_score(s1) : 0;
    e2    = m.prev2_present ? read_score(s2) : 0;
    total = e1 + e2;
    delta = 0;
    if (m.operation == chu_pkg::OP_REWARD || m.operation == chu_pkg::OP_PENALIZE) begin
      bonus = longint'(m.depth) * longint'(m.depth);
      if (bonus > BONUS_MAX) begin
        bonus = BONUS_MAX;
      end
      // A zero limit divides as if it were one.
      lim   = (gravity_limit_model == '0) ? 64'sd1 : longint'(gravity_limit_model);
      delta = bonus - (total * bonus) / lim;
      if (m.operation == chu_pkg::OP_PENALIZE) begin
        delta = -delta;
      end
      // The ply and the slot's range gate each write; the present bits only gate the reads.
      if (m.ply >= 8'd1) begin
        bump_score(s1, delta);
      end
      if (m.ply >= 8'd2) begin
        bump_score(s2, delta);
      end
    end
    r.first_score   = e1[chu_pkg::SCORE_W-1:0];
    r.second_score  = e2[chu_pkg::SCORE_W-1:0];
    r.sum_score     = total[chu_pkg::SUM_W-1:0];
    r.applied_delta = delta[chu_pkg::DELTA_W-1:0];
    return r;
  endfunction

  task automatic compare_field(input string name, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Each result beat is checked against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    score_beat_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_scores.size() == 0) begin
        $error("result beat with no command outstanding");
        mismatches++;
      end else begin
        want = pending_scores.pop_front();
        compare_field("first_score", $signed(want.first_score), first_score_o);
        compare_field("second_score", $signed(want.second_score), second_score_o);
        compare_field("sum_score", $signed(want.sum_score), sum_score_o);
        compare_field("applied_delta", $signed(want.applied_delta), applied_delta_o);
        results_checked++;
      end
    end
  end

  // Watchdog: too long without a command or result beat ends the run.
  always @(posedge clk_i) begin
    if ((start_i === 1'b1 && busy_o === 1'b0) || done_o === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Presents one command and holds it until the unit takes it.
  task automatic issue_move(input move_cmd_t m);
    start_i         <= 1'b1;
    operation_i     <= m.operation;
    depth_i         <= m.depth;
    cur_piece_i     <= m.cur_piece;
    to_square_i     <= m.to_square;
    prev1_piece_i   <= m.prev1_piece;
    prev1_to_i      <= m.prev1_to;
    prev1_present_i <= m.prev1_present;
    prev2_piece_i   <= m.prev2_piece;
    prev2_to_i      <= m.prev2_to;
    prev2_present_i <= m.prev2_present;
    ply_i           <= m.ply;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_scores.push_back(apply_move(m));
    items_sent++;
    if (m.operation == chu_pkg::OP_REWARD || m.operation == chu_pkg::OP_PENALIZE) begin
      updates_sent++;
    end
  endtask

  // Sender idles in bursts, with every third stretch of 60 commands left dense.
  task automatic sender_gap(input int pct);
    if (pct > 0 && (items_sent / 60) % 3 != 0 && $urandom_range(0, 99) < pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // Stops sending and waits until every owed beat has come and the unit is idle.
  task automatic wait_for_results();
    start_i <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk_i);
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  task automatic write_gravity_limit(input logic [chu_pkg::LIMIT_W-1:0] lim);
    wait_for_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    gravity_limit_model = lim;
    limits_written++;
  endtask

  function automatic move_cmd_t make_move(input logic [1:0] op,
                                          input int dep, mp, mt, p1, t1, pr1,
                                          input int p2, t2, pr2, ply);
    move_cmd_t m;
    m.operation     = op;
    m.depth         = dep[7:0];
    m.cur_piece     = mp[3:0];
    m.to_square     = mt[5:0];
    m.prev1_piece   = p1[3:0];
    m.prev1_to      = t1[5:0];
    m.prev1_present = pr1[0];
    m.prev2_piece   = p2[3:0];
    m.prev2_to      = t2[5:0];
    m.prev2_present = pr2[0];
    m.ply           = ply[7:0];
    return m;
  endfunction

  // Pieces and squares mostly come from a small pool so entries get revisited.
  function automatic logic [3:0] pick_piece();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 4'($urandom_range(0, 2));
    end else if (r < 92) begin
      return 4'($urandom_range(0, PIECES - 1));
    end
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [5:0] pick_square();
    if ($urandom_range(0, 99) < 70) begin
      return ($urandom_range(0, 3) == 3) ? 6'd63 : 6'($urandom_range(0, 2));
    end
    return 6'($urandom_range(0, 63));
  endfunction

  // One search node: query each candidate, then reward the best and penalize the rest.
  task automatic run_search_node(input int gap_pct);
    move_cmd_t ctx;
    move_cmd_t m;
    move_cmd_t cands [$];
    int        n;
    int        best;
    int        r;
    ctx.prev1_piece   = pick_piece();
    ctx.prev1_to      = pick_square();
    ctx.prev1_present = ($urandom_range(0, 9) != 0);
    ctx.prev2_piece   = pick_piece();
    ctx.prev2_to      = pick_square();
    ctx.prev2_present = ($urandom_range(0, 9) != 0);
    ctx.depth = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(1, 40))
                                             : 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 10) begin
      ctx.ply = 8'($urandom_range(0, 1));
    end else if (r < 85) begin
      ctx.ply = 8'($urandom_range(2, 30));
    end else begin
      ctx.ply = 8'($urandom_range(0, 255));
    end
    n    = $urandom_range(2, 5);
    best = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      m             = ctx;
      m.cur_piece   = pick_piece();
      m.to_square   = pick_square();
      m.operation   = chu_pkg::OP_QUERY;
      cands.push_back(m);
      sender_gap(gap_pct);
      issue_move(m);
    end
    for (int i = 0; i < n; i++) begin
      m           = cands[i];
      m.operation = (i == best) ? chu_pkg::OP_REWARD : chu_pkg::OP_PENALIZE;
      sender_gap(gap_pct);
      issue_move(m);
    end
  endtask

  // Noise: every field drawn over its whole range, unused operation code included.
  task automatic run_noise_move(input int gap_pct);
    move_cmd_t m;
    m = make_move(2'($urandom_range(0, 3)), $urandom_range(0, 255), $urandom_range(0, 15),
                  $urandom_range(0, 63), $urandom_range(0, 15), $urandom_range(0, 63),
                  $urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 63),
                  $urandom_range(0, 1), $urandom_range(0, 255));
    sender_gap(gap_pct);
    issue_move(m);
  endtask

  // One limit setting, then mostly search nodes with some noise mixed in.
  task automatic run_gravity_phase(input logic [chu_pkg::LIMIT_W-1:0] lim, input int n_items,
                                   input int gap_pct, input bit mid_pause);
    int target;
    bit paused;
    target = items_sent + n_items;
    paused = 1'b0;
    write_gravity_limit(lim);
    while (items_sent < target) begin
      if ($urandom_range(0, 4) == 0) begin
        run_noise_move(gap_pct);
      end else begin
        run_search_node(gap_pct);
      end
      // Once, halfway, when asked, the host holds off until every outstanding beat is back.
      if (mid_pause && !paused && items_sent >= target - n_items / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
    end
  endtask

  // Corner moves at the reset limit on a cleared table.
  task automatic test_corner_moves();
    // Query of a cleared table, then a reward at full depth where the bonus caps.
    issue_move(make_move(chu_pkg::OP_QUERY,      0,  0,  0,  0,  0, 1,  1,  1, 1,   0));
    issue_move(make_move(chu_pkg::OP_REWARD,   255,  0,  0,  0,  0, 1,  1,  1, 1,   2));
    issue_move(make_move(chu_pkg::OP_QUERY,      0,  0,  0,  0,  0, 1,  1,  1, 1,   0));
    issue_move(make_move(chu_pkg::OP_PENALIZE,  34,  0,  0,  0,  0, 1,  1,  1, 1,   2));
    // Unused operation code acts as a query.
    issue_move(make_move(OP_UNUSED,            255,  0,  0,  0,  0, 1,  1,  1, 1, 255));
    // Zero depth gives a zero bonus; ply 1 and ply 0 gate the writes.
    issue_move(make_move(chu_pkg::OP_REWARD,     0,  0,  0,  0,  0, 1,  1,  1, 1,   2));
    issue_move(make_move(chu_pkg::OP_REWARD,    35,  0,  0,  0,  0, 1,  1,  1, 1,   1));
    issue_move(make_move(chu_pkg::OP_PENALIZE,  35,  0,  0,  0,  0, 1,  1,  1, 1,   0));
    issue_move(make_move(chu_pkg::OP_QUERY,      0,  0,  0,  0,  0, 1,  1,  1, 1,   0));
    // Writes still land when the earlier moves are absent.
    issue_move(make_move(chu_pkg::OP_REWARD,    20,  5, 10,  3,  7, 0,  4,  8, 0,   2));
    issue_move(make_move(chu_pkg::OP_QUERY,      0,  5, 10,  3,  7, 1,  4,  8, 1,   0));
    // Pieces off the table read as zero and are never written.
    issue_move(make_move(chu_pkg::OP_REWARD,   255, 15, 63,  0,  0, 1,  1,  1, 1, 255));
    issue_move(make_move(chu_pkg::OP_REWARD,   255, 11, 63, 12, 63, 1, 11, 63, 1,   2));
    issue_move(make_move(chu_pkg::OP_QUERY,      0, 11, 63, 12, 63, 1, 11, 63, 1,   0));
    issue_move(make_move(chu_pkg::OP_PENALIZE, 170, 10, 21, 15, 21, 1, 13, 42, 1, 128));
    // Both earlier moves pick the same entry, which takes the delta twice.
    issue_move(make_move(chu_pkg::OP_REWARD,   200,  6, 33,  9, 42, 1,  9, 42, 1,   2));
    issue_move(make_move(chu_pkg::OP_QUERY,      0,  6, 33,  9, 42, 1,  9, 42, 1,   0));
    issue_move(make_move(chu_pkg::OP_PENALIZE,   1,  0,  0,  0,  0, 1,  1,  1, 1,   2));
    issue_move(make_move(chu_pkg::OP_QUERY,      0,  0,  0,  0,  0, 1,  1,  1, 1,   0));
  endtask

  // Limits of 1 and 0 make the gravity term explode, so entries saturate.
  task automatic test_saturating_limits();
    run_gravity_phase(chu_pkg::LIMIT_W'(1), 250, GAP_PCT, 1'b0);
    run_gravity_phase(chu_pkg::LIMIT_W'(0), 150, GAP_PCT, 1'b0);
  endtask

  // Large and random limits, up to the widest value the register holds.
  task automatic test_wide_limits();
    run_gravity_phase(chu_pkg::LIMIT_W'(1048576), 250, GAP_PCT, 1'b0);
    run_gravity_phase({chu_pkg::LIMIT_W{1'b1}}, 200, GAP_PCT, 1'b0);
    run_gravity_phase(chu_pkg::LIMIT_W'($urandom_range(1, 65536)), 300, GAP_PCT, 1'b0);
  endtask

  // Back at the reset limit, with the sender draining the unit halfway through.
  task automatic test_host_pause();
    run_gravity_phase(chu_pkg::LIMIT_RESET, 250, GAP_PCT, 1'b1);
  endtask

  // Final stretch: commands offered on every cycle the unit will take them.
  task automatic test_back_to_back();
    run_gravity_phase(chu_pkg::LIMIT_W'($urandom_range(1, 4096)), 250, 0, 1'b0);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The unit clears its table after reset while busy is high.
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);

    test_corner_moves();
    test_saturating_limits();
    test_wide_limits();
    test_host_pause();
    test_back_to_back();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_scores.size() != 0) begin
      $error("%0d result beats never arrived", pending_scores.size());
      mismatches++;
    end

    $display("Checked %0d result beats for %0d commands (%0d rewards or penalties).",
             results_checked, items_sent, updates_sent);
    $display("Ran %0d gravity limit settings, zero, one and the register maximum among them.",
             limits_written);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
